// ===== design/rtc_pkg.sv =====
// shared types, codes and calendar helpers for the calendar clock
package rtc_pkg;

  localparam int unsigned DATA_W = 48;
  localparam logic [2:0] START_WEEKDAY = 3'd1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ROLL_NONE   = 3'd0,
    ROLL_MINUTE = 3'd1,
    ROLL_HOUR   = 3'd2,
    ROLL_DAY    = 3'd3,
    ROLL_MONTH  = 3'd4,
    ROLL_YEAR   = 3'd5
  } roll_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

endpackage

// ===== design/rtc_calendar_counter.sv =====
// calendar clock top level: input register, calendar state and result register
// path: an accepted input beat goes into the input register, and its result into the result register
// throughput: one beat per cycle while the result channel is not stalled, set by the combinational
// calendar update between the input register and the result register
// reset: time 00:00:00 on 1 January of START_YEAR, weekday START_WEEKDAY, no beats held
module rtc_calendar_counter
  import rtc_pkg::*;
#(
  parameter int START_YEAR = 1900,
  parameter int MAX_YEAR   = 9999
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // set_year, set_month, set_day, set_hour, set_minute, set_second, set_weekday, zero pad
  input  logic [DATA_W-1:0] in_tdata,
  // opcode
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // year, month, day, hour, minute, second, weekday, rollover_level, zero pad
  output logic [DATA_W-1:0] out_tdata,
  // set_rejected
  output logic              out_tuser
);

  logic  s1_valid_r;
  op_t   s1_op_r;
  cal_t  s1_set_r;
  cal_t  cur_r;
  cal_t  cur_nxt;
  roll_t level;
  logic  rejected;
  logic  s1_adv;
  logic  out_valid_r;
  cal_t  out_cal_r;
  roll_t out_level_r;
  logic  out_rej_r;
  cal_t  in_cal;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    in_cal.year    = in_tdata[13:0];
    in_cal.month   = in_tdata[17:14];
    in_cal.day     = in_tdata[22:18];
    in_cal.hour    = in_tdata[27:23];
    in_cal.minute  = in_tdata[33:28];
    in_cal.second  = in_tdata[39:34];
    in_cal.weekday = in_tdata[42:40];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= op_t'(in_tuser);
      s1_set_r <= in_cal;
    end
  end

  rtc_calc #(
    .START_YEAR(START_YEAR),
    .MAX_YEAR  (MAX_YEAR)
  ) u_calc (
    .op      (s1_op_r),
    .set_val (s1_set_r),
    .cur     (cur_r),
    .cal_nxt (cur_nxt),
    .level   (level),
    .rejected(rejected)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.year    <= 14'(START_YEAR);
      cur_r.month   <= 4'd1;
      cur_r.day     <= 5'd1;
      cur_r.hour    <= 5'd0;
      cur_r.minute  <= 6'd0;
      cur_r.second  <= 6'd0;
      cur_r.weekday <= START_WEEKDAY;
    end else if (s1_adv) begin
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cal_r   <= cur_nxt;
      out_level_r <= level;
      out_rej_r   <= rejected;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rej_r;
  assign out_tdata  = {2'b00, out_level_r, out_cal_r.weekday, out_cal_r.second,
                       out_cal_r.minute, out_cal_r.hour, out_cal_r.day,
                       out_cal_r.month, out_cal_r.year};

endmodule

// ===== design/rtc_calc.sv =====
// next calendar value for one tick or set beat, with set validation
module rtc_calc
  import rtc_pkg::*;
#(
  parameter int START_YEAR = 1900,
  parameter int MAX_YEAR   = 9999
) (
  input  op_t         op,
  input  cal_t        set_val,
  input  cal_t        cur,
  output cal_t        cal_nxt,
  output roll_t       level,
  output logic        rejected
);

  logic       set_ok;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;
  cal_t       tick_val;
  logic [4:0] cur_len;

  always_comb begin
    set_ok = 1'b1;
    if (set_val.year < 14'(START_YEAR) || set_val.year > 14'(MAX_YEAR)) set_ok = 1'b0;
    if (set_val.month == 4'd0 || set_val.month > 4'd12) set_ok = 1'b0;
    if (set_val.day == 5'd0 || set_val.day > month_len(set_val.month, set_val.year)) set_ok = 1'b0;
    if (set_val.hour > 5'd23 || set_val.minute > 6'd59) set_ok = 1'b0;
    if (set_val.second > 6'd59 || set_val.weekday > 3'd6) set_ok = 1'b0;
  end

  assign cur_len   = month_len(cur.month, cur.year);
  assign sec_wrap  = cur.second >= 6'd59;
  assign min_wrap  = sec_wrap && (cur.minute >= 6'd59);
  assign hour_wrap = min_wrap && (cur.hour >= 5'd23);
  assign day_wrap  = hour_wrap && (cur.day >= cur_len);
  assign mon_wrap  = day_wrap && (cur.month >= 4'd12);

  always_comb begin
    tick_val = cur;
    tick_val.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
    if (sec_wrap) begin
      tick_val.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
    end
    if (min_wrap) begin
      tick_val.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
    end
    if (hour_wrap) begin
      tick_val.day     = day_wrap ? 5'd1 : cur.day + 5'd1;
      tick_val.weekday = (cur.weekday >= 3'd6) ? 3'd0 : cur.weekday + 3'd1;
    end
    if (day_wrap) begin
      tick_val.month = mon_wrap ? 4'd1 : cur.month + 4'd1;
    end
    if (mon_wrap && (cur.year < 14'(MAX_YEAR))) begin
      tick_val.year = cur.year + 14'd1;
    end
  end

  always_comb begin
    cal_nxt  = cur;
    level    = ROLL_NONE;
    rejected = 1'b0;
    case (op)
      OP_TICK: begin
        cal_nxt = tick_val;
        if (mon_wrap)       level = ROLL_YEAR;
        else if (day_wrap)  level = ROLL_MONTH;
        else if (hour_wrap) level = ROLL_DAY;
        else if (min_wrap)  level = ROLL_HOUR;
        else if (sec_wrap)  level = ROLL_MINUTE;
        else                level = ROLL_NONE;
      end
      OP_SET: begin
        if (set_ok) cal_nxt = set_val;
        else rejected = 1'b1;
      end
      default: begin
        cal_nxt = cur;
      end
    endcase
  end

endmodule

// ===== tb/sv/rtc_calendar_counter_test.sv =====
// self-checking testbench for the calendar clock: directed and random ticks and sets
`timescale 1ns / 1ps
module rtc_calendar_counter_test;
  import rtc_pkg::*;

  localparam int START_YEAR = 1900;
  localparam int MAX_YEAR   = 9999;

  typedef struct packed {
    cal_t  cal;
    roll_t roll;
    logic  rejected;
  } reading_t;

  class calendar_tracker;
    cal_t     now;
    reading_t expected_q[$];
    int       mismatches;
    int       tick_count;
    int       sets_loaded;
    int       sets_rejected;
    int       top_year_holds;
    int       roll_seen[6];

    function new();
      now.year    = 14'(START_YEAR);
      now.month   = 4'd1;
      now.day     = 5'd1;
      now.hour    = 5'd0;
      now.minute  = 6'd0;
      now.second  = 6'd0;
      now.weekday = START_WEEKDAY;
    endfunction

    function int unsigned days_in(logic [3:0] m, logic [13:0] y);
      case (m)
        4'd2: begin
          return (y % 4 == 0) ? 29 : 28;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    function bit set_valid(cal_t f);
      if (f.year < START_YEAR || f.year > MAX_YEAR) return 1'b0;
      if (f.month == 0 || f.month > 12) return 1'b0;
      if (f.day == 0 || f.day > days_in(f.month, f.year)) return 1'b0;
      return f.hour <= 23 && f.minute <= 59 && f.second <= 59 && f.weekday <= 6;
    endfunction

    function roll_t tick_forward();
      roll_t lvl;
      lvl = ROLL_NONE;
      if (now.second < 59) begin
        now.second = now.second + 6'd1;
      end else begin
        now.second = 6'd0;
        lvl = ROLL_MINUTE;
        if (now.minute < 59) begin
          now.minute = now.minute + 6'd1;
        end else begin
          now.minute = 6'd0;
          lvl = ROLL_HOUR;
          if (now.hour < 23) begin
            now.hour = now.hour + 5'd1;
          end else begin
            now.hour = 5'd0;
            lvl = ROLL_DAY;
            now.weekday = (now.weekday >= 6) ? 3'd0 : now.weekday + 3'd1;
            if (now.day < days_in(now.month, now.year)) begin
              now.day = now.day + 5'd1;
            end else begin
              now.day = 5'd1;
              lvl = ROLL_MONTH;
              if (now.month < 12) begin
                now.month = now.month + 4'd1;
              end else begin
                now.month = 4'd1;
                lvl = ROLL_YEAR;
                if (now.year < MAX_YEAR) now.year = now.year + 14'd1;
                else top_year_holds++;
              end
            end
          end
        end
      end
      return lvl;
    endfunction

    function void note_beat(op_t op, cal_t req);
      reading_t r;
      r.roll = ROLL_NONE;
      r.rejected = 1'b0;
      if (op == OP_TICK) begin
        r.roll = tick_forward();
        tick_count++;
        roll_seen[r.roll]++;
      end else if (set_valid(req)) begin
        now = req;
        sets_loaded++;
      end else begin
        r.rejected = 1'b1;
        sets_rejected++;
      end
      r.cal = now;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_beat(cal_t got, logic [2:0] got_roll, logic got_rej);
      reading_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat arrived with nothing pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("year", 32'(want.cal.year), 32'(got.year));
      compare_field("month", 32'(want.cal.month), 32'(got.month));
      compare_field("day", 32'(want.cal.day), 32'(got.day));
      compare_field("hour", 32'(want.cal.hour), 32'(got.hour));
      compare_field("minute", 32'(want.cal.minute), 32'(got.minute));
      compare_field("second", 32'(want.cal.second), 32'(got.second));
      compare_field("weekday", 32'(want.cal.weekday), 32'(got.weekday));
      compare_field("rollover_level", 32'(want.roll), 32'(got_roll));
      compare_field("set_rejected", 32'(want.rejected), 32'(got_rej));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;

  int send_idle_pct = 20;
  int recv_stall_pct = 75;

  calendar_tracker tracker = new();

  rtc_calendar_counter #(
    .START_YEAR(START_YEAR),
    .MAX_YEAR  (MAX_YEAR)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] pack_request(cal_t f);
    return {5'b0, f.weekday, f.second, f.minute, f.hour, f.day, f.month, f.year};
  endfunction

  function automatic cal_t unpack_fields(logic [DATA_W-1:0] d);
    cal_t f;
    f.year    = d[13:0];
    f.month   = d[17:14];
    f.day     = d[22:18];
    f.hour    = d[27:23];
    f.minute  = d[33:28];
    f.second  = d[39:34];
    f.weekday = d[42:40];
    return f;
  endfunction

  function automatic cal_t make_edge_set();
    cal_t        f;
    int unsigned len;
    f.year = 14'(($urandom_range(7) == 0) ? $urandom_range(MAX_YEAR - 3, MAX_YEAR)
                                          : $urandom_range(START_YEAR, MAX_YEAR));
    f.month = 4'($urandom_range(1, 12));
    len = tracker.days_in(f.month, f.year);
    f.day = 5'(($urandom_range(2) != 0) ? len - $urandom_range(0, 1)
                                        : $urandom_range(1, len));
    f.hour = 5'(($urandom_range(3) != 0) ? 23 : $urandom_range(0, 23));
    f.minute = 6'(($urandom_range(3) != 0) ? 59 : $urandom_range(0, 59));
    f.second = 6'(($urandom_range(3) != 0) ? $urandom_range(57, 59) : $urandom_range(0, 59));
    f.weekday = 3'($urandom_range(0, 6));
    return f;
  endfunction

  function automatic cal_t break_set(cal_t f);
    int unsigned len;
    len = tracker.days_in(f.month, f.year);
    case ($urandom_range(6))
      0: f.year = 14'($urandom_range(1) ? $urandom_range(0, START_YEAR - 1)
                                        : $urandom_range(MAX_YEAR + 1, 16383));
      1: f.month = 4'($urandom_range(1) ? 0 : $urandom_range(13, 15));
      2: f.day = 5'((len == 31 || $urandom_range(1)) ? 0 : $urandom_range(len + 1, 31));
      3: f.hour = 5'($urandom_range(24, 31));
      4: f.minute = 6'($urandom_range(60, 63));
      5: f.second = 6'($urandom_range(60, 63));
      default: f.weekday = 3'd7;
    endcase
    return f;
  endfunction

  // scoreboard hooks on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_beat(op_t'(in_tuser), unpack_fields(in_tdata));
      if (out_tvalid && out_tready)
        tracker.check_beat(unpack_fields(out_tdata), out_tdata[45:43], out_tuser);
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(op_t op, cal_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pack_request(f);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, unpack_fields(DATA_W'({$urandom, $urandom})));
  endtask

  task automatic send_set(int y, int mo, int d, int h, int mi, int s, int w);
    cal_t f;
    f.year    = 14'(y);
    f.month   = 4'(mo);
    f.day     = 5'(d);
    f.hour    = 5'(h);
    f.minute  = 6'(mi);
    f.second  = 6'(s);
    f.weekday = 3'(w);
    send_item(OP_SET, f);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_tick();
    send_set(1900, 2, 28, 23, 59, 59, 3);
    send_tick();
    send_set(2023, 2, 28, 23, 59, 59, 2);
    send_tick();
    send_set(2024, 4, 30, 23, 59, 59, 6);
    send_tick();
    send_set(MAX_YEAR, 12, 31, 23, 59, 59, 5);
    send_tick();
    send_set(2000, 6, 15, 10, 59, 59, 0);
    send_tick();
    // rejected loads
    send_set(START_YEAR - 1, 6, 1, 0, 0, 0, 0);
    send_set(MAX_YEAR + 1, 6, 1, 0, 0, 0, 0);
    send_set(2001, 0, 1, 0, 0, 0, 0);
    send_set(2001, 13, 1, 0, 0, 0, 0);
    send_set(2001, 5, 0, 0, 0, 0, 0);
    send_set(2001, 4, 31, 0, 0, 0, 0);
    send_set(2023, 2, 29, 0, 0, 0, 0);
    send_set(2001, 5, 5, 24, 0, 0, 0);
    send_set(2001, 5, 5, 0, 60, 0, 0);
    send_set(2001, 5, 5, 0, 0, 60, 0);
    send_set(2001, 5, 5, 0, 0, 0, 7);
    send_set(16383, 15, 31, 31, 63, 63, 7);
  endtask

  task automatic run_random(int n_items);
    int sent;
    int kind;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        send_item(OP_SET, make_edge_set());
        burst = $urandom_range(1, 5);
        repeat (burst) send_tick();
        sent += burst + 1;
      end else if (kind <= 7) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_tick();
        sent += burst;
      end else if (kind == 8) begin
        send_item(OP_SET, unpack_fields(DATA_W'({$urandom, $urandom})));
        sent++;
      end else begin
        send_item(OP_SET, break_set(make_edge_set()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(260);
    drain();
    send_idle_pct  = 75;
    recv_stall_pct = 20;
    run_random(270);
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(270);
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks, %0d loads taken, %0d loads refused",
             tracker.tick_count, tracker.sets_loaded, tracker.sets_rejected);
    $display("carries: %0d minute, %0d hour, %0d day, %0d month, %0d year (%0d held at top)",
             tracker.roll_seen[ROLL_MINUTE], tracker.roll_seen[ROLL_HOUR],
             tracker.roll_seen[ROLL_DAY], tracker.roll_seen[ROLL_MONTH],
             tracker.roll_seen[ROLL_YEAR], tracker.top_year_holds);
    if (tracker.pending() != 0)
      $display("%0d expected results never arrived", tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rtc_pkg.sv
design/rtc_calc.sv
design/rtc_calendar_counter.sv
tb/sv/rtc_calendar_counter_test.sv
